@@ sv/fdpa_pkg.sv @@
// Shared constants, tables and helper functions of the frameshift DNA/protein aligner.
`timescale 1ns / 1ps

package fdpa_pkg;

  localparam int MaxDna     = 4096;
  localparam int MaxProtein = 1024;
  localparam int Cols       = MaxProtein + 1;

  localparam int DnaAw  = $clog2(MaxDna);
  localparam int ProtAw = $clog2(MaxProtein);
  localparam int ColAw  = $clog2(Cols);
  localparam int DnaCw  = $clog2(MaxDna + 1);
  localparam int ProtCw = $clog2(MaxProtein + 1);

  localparam int AccW = 20;

  typedef enum logic [1:0] {
    CMD_DNA  = 2'd0,
    CMD_PROT = 2'd1,
    CMD_RUN  = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_GAP_EXTEND = 2'd0,
    REG_GAP_OPEN   = 2'd1,
    REG_FRAMESHIFT = 2'd2,
    REG_UNUSED     = 2'd3
  } reg_e;

  localparam logic [2:0] BadBase = 3'd4;
  localparam logic [4:0] BadRes  = 5'd24;
  localparam logic signed [15:0] NegScore = -16'sd999;

  // Step numbers of the per-cell sequence on the shared add/max unit.
  localparam logic [3:0] StepIvA  = 4'd0;
  localparam logic [3:0] StepIvB  = 4'd1;
  localparam logic [3:0] StepDA   = 4'd2;
  localparam logic [3:0] StepDB   = 4'd3;
  localparam logic [3:0] StepCIv  = 4'd4;
  localparam logic [3:0] StepCD   = 4'd5;
  localparam logic [3:0] StepCFs2 = 4'd6;
  localparam logic [3:0] StepCIn  = 4'd7;
  localparam logic [3:0] StepCFs4 = 4'd8;

  // Amino acid index of each codon, codon index 16*b0 + 4*b1 + b2 (A C G T).
  localparam int CodonAa [64] = '{
    11, 2, 11, 2, 16, 16, 16, 16, 1, 15, 1, 15, 9, 9, 12, 9,
    5, 8, 5, 8, 14, 14, 14, 14, 1, 1, 1, 1, 10, 10, 10, 10,
    6, 3, 6, 3, 0, 0, 0, 0, 7, 7, 7, 7, 19, 19, 19, 19,
    23, 18, 23, 18, 15, 15, 15, 15, 23, 4, 17, 4, 10, 13, 10, 13};

  localparam int Blosum62 [24][24] = '{
    '{ 4,-1,-2,-2, 0,-1,-1, 0,-2,-1,-1,-1,-1,-2,-1, 1, 0,-3,-2, 0,-2,-1, 0,-4},
    '{-1, 5, 0,-2,-3, 1, 0,-2, 0,-3,-2, 2,-1,-3,-2,-1,-1,-3,-2,-3,-1, 0,-1,-4},
    '{-2, 0, 6, 1,-3, 0, 0, 0, 1,-3,-3, 0,-2,-3,-2, 1, 0,-4,-2,-3, 3, 0,-1,-4},
    '{-2,-2, 1, 6,-3, 0, 2,-1,-1,-3,-4,-1,-3,-3,-1, 0,-1,-4,-3,-3, 4, 1,-1,-4},
    '{ 0,-3,-3,-3, 9,-3,-4,-3,-3,-1,-1,-3,-1,-2,-3,-1,-1,-2,-2,-1,-3,-3,-2,-4},
    '{-1, 1, 0, 0,-3, 5, 2,-2, 0,-3,-2, 1, 0,-3,-1, 0,-1,-2,-1,-2, 0, 3,-1,-4},
    '{-1, 0, 0, 2,-4, 2, 5,-2, 0,-3,-3, 1,-2,-3,-1, 0,-1,-3,-2,-2, 1, 4,-1,-4},
    '{ 0,-2, 0,-1,-3,-2,-2, 6,-2,-4,-4,-2,-3,-3,-2, 0,-2,-2,-3,-3,-1,-2,-1,-4},
    '{-2, 0, 1,-1,-3, 0, 0,-2, 8,-3,-3,-1,-2,-1,-2,-1,-2,-2, 2,-3, 0, 0,-1,-4},
    '{-1,-3,-3,-3,-1,-3,-3,-4,-3, 4, 2,-3, 1, 0,-3,-2,-1,-3,-1, 3,-3,-3,-1,-4},
    '{-1,-2,-3,-4,-1,-2,-3,-4,-3, 2, 4,-2, 2, 0,-3,-2,-1,-2,-1, 1,-4,-3,-1,-4},
    '{-1, 2, 0,-1,-3, 1, 1,-2,-1,-3,-2, 5,-1,-3,-1, 0,-1,-3,-2,-2, 0, 1,-1,-4},
    '{-1,-1,-2,-3,-1, 0,-2,-3,-2, 1, 2,-1, 5, 0,-2,-1,-1,-1,-1, 1,-3,-1,-1,-4},
    '{-2,-3,-3,-3,-2,-3,-3,-3,-1, 0, 0,-3, 0, 6,-4,-2,-2, 1, 3,-1,-3,-3,-1,-4},
    '{-1,-2,-2,-1,-3,-1,-1,-2,-2,-3,-3,-1,-2,-4, 7,-1,-1,-4,-3,-2,-2,-1,-2,-4},
    '{ 1,-1, 1, 0,-1, 0, 0, 0,-1,-2,-2, 0,-1,-2,-1, 4, 1,-3,-2,-2, 0, 0, 0,-4},
    '{ 0,-1, 0,-1,-1,-1,-1,-2,-2,-1,-1,-1,-1,-2,-1, 1, 5,-2,-2, 0,-1,-1, 0,-4},
    '{-3,-3,-4,-4,-2,-2,-3,-2,-2,-3,-2,-3,-1, 1,-4,-3,-2,11, 2,-3,-4,-3,-2,-4},
    '{-2,-2,-2,-3,-2,-1,-2,-3, 2,-1,-1,-2,-1, 3,-3,-2,-2, 2, 7,-1,-3,-2,-1,-4},
    '{ 0,-3,-3,-3,-1,-2,-2,-3,-3, 3, 1,-2, 1,-1,-2,-2, 0,-3,-1, 4,-3,-2,-1,-4},
    '{-2,-1, 3, 4,-3, 0, 1,-1, 0,-3,-4, 0,-3,-3,-2, 0,-1,-4,-3,-3, 4, 1,-1,-4},
    '{-1, 0, 0, 1,-3, 3, 4,-2, 0,-3,-3, 1,-1,-3,-1, 0,-1,-3,-2,-2, 1, 4,-1,-4},
    '{ 0,-1,-1,-1,-2,-1,-1,-1,-1,-1,-1,-1,-1,-1,-2, 0, 0,-2,-1,-1,-1,-1,-1,-4},
    '{-4,-4,-4,-4,-4,-4,-4,-4,-4,-4,-4,-4,-4,-4,-4,-4,-4,-4,-4,-4,-4,-4,-4, 1}};

  function automatic logic [2:0] base_code(input logic [7:0] sym);
    logic [2:0] b;
    case (sym)
      "A": b = 3'd0;
      "C": b = 3'd1;
      "G": b = 3'd2;
      "T": b = 3'd3;
      default: b = BadBase;
    endcase
    return b;
  endfunction

  function automatic logic [4:0] res_code(input logic [7:0] sym);
    logic [4:0] r;
    case (sym)
      "A": r = 5'd0;
      "R": r = 5'd1;
      "N": r = 5'd2;
      "D": r = 5'd3;
      "C": r = 5'd4;
      "Q": r = 5'd5;
      "E": r = 5'd6;
      "G": r = 5'd7;
      "H": r = 5'd8;
      "I": r = 5'd9;
      "L": r = 5'd10;
      "K": r = 5'd11;
      "M": r = 5'd12;
      "F": r = 5'd13;
      "P": r = 5'd14;
      "S": r = 5'd15;
      "T": r = 5'd16;
      "W": r = 5'd17;
      "Y": r = 5'd18;
      "V": r = 5'd19;
      "B": r = 5'd20;
      "Z": r = 5'd21;
      "X": r = 5'd22;
      "*": r = 5'd23;
      default: r = BadRes;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [AccW-1:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -20'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

@@ sv/frameshift_dna_protein_align.sv @@
// Top level of the frameshift-aware DNA/protein aligner over both strands.
`timescale 1ns / 1ps

// Letters are loaded one per beat: command 0 appends a DNA base, command 1 appends a
// protein residue, and busy stays low during an append. Command 2 runs the alignment
// over the strand and its reverse complement and then clears both strings; command 3
// does nothing. A run raises busy and walks every cell of the score tables on one
// shared add-and-max unit, a memory read and then nine steps a cell.
// When fewer than six bases or no residues are loaded the result comes in the
// cycle after the command with empty_run set. The result is shown for exactly one
// cycle with done_o high and cannot be held off by the receiver, so it must be
// captured in that cycle. Configuration writes are always accepted and should
// only be issued while busy is low.
module frameshift_dna_protein_align (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command_i,
  input  logic [7:0]  symbol_i,
  output logic        done_o,
  output logic signed [15:0] best_score_o,
  output logic        empty_run_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_F0,
    ST_F1,
    ST_F2,
    ST_F3,
    ST_F4,
    ST_RD,
    ST_EX
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [7:0] ge_q, go_q, fs_q;
  logic [8:0] gog;

  // Loaded strings.
  logic [fdpa_pkg::DnaCw-1:0]  dna_cnt_q;
  logic [fdpa_pkg::ProtCw-1:0] prot_cnt_q;
  logic [2:0] dna_mem [fdpa_pkg::MaxDna];
  logic [4:0] prot_mem [fdpa_pkg::MaxProtein];
  logic [2:0] dna_q;
  logic [4:0] prot_q;
  logic       dna_we, dna_re, prot_we, prot_re;
  logic [fdpa_pkg::DnaAw-1:0] dna_ra;
  logic [2:0] dna_wd;
  logic [4:0] prot_wd;

  // Rolling rows of C (four) and D (three).
  logic signed [15:0] c_mem [4][fdpa_pkg::Cols];
  logic signed [15:0] d_mem [3][fdpa_pkg::Cols];
  logic signed [15:0] c_rd [4];
  logic signed [15:0] d_rd [3];
  logic row_re, row_we;

  // Sequencer state.
  logic [fdpa_pkg::DnaCw-1:0]  i_q;
  logic [fdpa_pkg::ColAw-1:0]  j_q;
  logic [1:0]  ds_q;
  logic [3:0]  step_q;
  logic        strand_q;
  logic [2:0]  b0_q, b1_q, b2_q;
  logic [4:0]  aa_q;

  // Cell values.
  logic signed [15:0] iv_q, d_q, cprev_q, c2m1_q, c3m1_q, old_q, best_q;
  logic signed [fdpa_pkg::AccW-1:0] acc_q, acc_d;

  // Result registers.
  logic        done_q, empty_q;
  logic signed [15:0] score_q;

  // Shared unit operands.
  logic signed [fdpa_pkg::AccW-1:0] tx, ty, cand;
  logic [8:0]  tz;
  logic        first;

  logic [1:0]  cs, c2, c3;
  logic        row1, row_ge3, row_ge4, row4;
  logic signed [10:0] s_val;
  logic signed [15:0] c_val, best_upd, old_term;
  logic [fdpa_pkg::DnaCw-1:0] base_k, base_addr;
  logic [2:0]  base_fix;
  logic        run_empty, last_col, last_row;

  assign gog = {1'b0, ge_q} + {1'b0, go_q};

  assign cs = i_q[1:0];
  assign c2 = cs - 2'd2;
  assign c3 = cs - 2'd3;
  assign row1    = (i_q == fdpa_pkg::DnaCw'(1));
  assign row4    = (i_q == fdpa_pkg::DnaCw'(4));
  assign row_ge3 = (i_q >= fdpa_pkg::DnaCw'(3));
  assign row_ge4 = (i_q >= fdpa_pkg::DnaCw'(4));

  assign last_col = (j_q == fdpa_pkg::ColAw'(prot_cnt_q));
  assign last_row = (i_q == dna_cnt_q - fdpa_pkg::DnaCw'(2));
  assign run_empty = (dna_cnt_q < fdpa_pkg::DnaCw'(6)) ||
                     (prot_cnt_q == '0);

  // Codon score of the current residue; any invalid base or letter scores -999.
  always_comb begin
    if (aa_q >= fdpa_pkg::BadRes || prot_q >= fdpa_pkg::BadRes) begin
      s_val = fdpa_pkg::NegScore[10:0];
    end else begin
      s_val = 11'(fdpa_pkg::Blosum62[prot_q][aa_q]);
    end
  end

  // The row four rows back is the all-zero top row when the current row is four.
  assign old_term = row4 ? 16'sd0 : old_q;

  // Codon fetch address: positions i-1, i, i+1, mirrored for the reverse strand.
  always_comb begin
    case (state_q)
      ST_F1:   base_k = i_q;
      ST_F2:   base_k = i_q + fdpa_pkg::DnaCw'(1);
      default: base_k = i_q - fdpa_pkg::DnaCw'(1);
    endcase
    base_addr = strand_q ? (dna_cnt_q - fdpa_pkg::DnaCw'(1) - base_k) : base_k;
  end

  assign base_fix = (dna_q >= fdpa_pkg::BadBase) ? fdpa_pkg::BadBase :
                    (strand_q ? (3'd3 - dna_q) : dna_q);

  // Operand selection for the shared unit: cand = tx + ty - tz, folded into a running max.
  always_comb begin
    tx    = '0;
    ty    = '0;
    tz    = '0;
    first = 1'b0;
    case (step_q)
      fdpa_pkg::StepIvA: begin
        tx    = 20'(iv_q);
        tz    = {1'b0, ge_q};
        first = 1'b1;
      end
      fdpa_pkg::StepIvB: begin
        tx = 20'(cprev_q);
        tz = gog;
      end
      fdpa_pkg::StepDA: begin
        tx    = 20'(d_rd[ds_q]);
        tz    = {1'b0, ge_q};
        first = 1'b1;
      end
      fdpa_pkg::StepDB: begin
        tx = 20'(c_rd[c3]);
        tz = gog;
      end
      fdpa_pkg::StepCIv: begin
        tx    = 20'(iv_q);
        first = 1'b1;
      end
      fdpa_pkg::StepCD: begin
        tx = 20'(d_q);
      end
      fdpa_pkg::StepCFs2: begin
        tx = row_ge3 ? 20'(c2m1_q) : '0;
        ty = 20'(s_val);
        tz = row1 ? 9'd0 : {1'b0, fs_q};
      end
      fdpa_pkg::StepCIn: begin
        // Rows one to three are clamped at zero here.
        if (row_ge4) begin
          tx = 20'(c3m1_q);
          ty = 20'(s_val);
        end
      end
      fdpa_pkg::StepCFs4: begin
        if (row_ge4) begin
          tx = 20'(old_term);
          ty = 20'(s_val);
          tz = {1'b0, fs_q};
        end
      end
      default: begin
        first = 1'b1;
      end
    endcase
    cand  = tx + ty - $signed({11'b0, tz});
    acc_d = (first || cand > acc_q) ? cand : acc_q;
  end

  assign c_val    = fdpa_pkg::sat16(acc_d);
  assign best_upd = (row_ge4 && c_val > best_q) ? c_val : best_q;

  // Memory controls.
  assign dna_we  = (state_q == ST_IDLE) && start && (command_i == fdpa_pkg::CMD_DNA) &&
                   (dna_cnt_q < fdpa_pkg::DnaCw'(fdpa_pkg::MaxDna));
  assign prot_we = (state_q == ST_IDLE) && start && (command_i == fdpa_pkg::CMD_PROT) &&
                   (prot_cnt_q < fdpa_pkg::ProtCw'(fdpa_pkg::MaxProtein));
  assign dna_wd  = fdpa_pkg::base_code(symbol_i);
  assign prot_wd = fdpa_pkg::res_code(symbol_i);
  assign dna_re  = (state_q == ST_F0) || (state_q == ST_F1) || (state_q == ST_F2);
  assign dna_ra  = base_addr[fdpa_pkg::DnaAw-1:0];
  assign prot_re = (state_q == ST_RD);
  assign row_re  = (state_q == ST_RD);
  assign row_we  = (state_q == ST_EX) && (step_q == fdpa_pkg::StepCFs4);

  always_ff @(posedge clk_i) begin
    if (dna_we) begin
      dna_mem[dna_cnt_q[fdpa_pkg::DnaAw-1:0]] <= dna_wd;
    end
    if (dna_re) begin
      dna_q <= dna_mem[dna_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (prot_we) begin
      prot_mem[prot_cnt_q[fdpa_pkg::ProtAw-1:0]] <= prot_wd;
    end
    if (prot_re) begin
      prot_q <= prot_mem[fdpa_pkg::ProtAw'(j_q - fdpa_pkg::ColAw'(1))];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 4; r++) begin
      if (row_we && cs == 2'(r)) begin
        c_mem[r][j_q] <= c_val;
      end
      if (row_re) begin
        c_rd[r] <= c_mem[r][j_q];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      if (row_we && ds_q == 2'(r)) begin
        d_mem[r][j_q] <= d_q;
      end
      if (row_re) begin
        d_rd[r] <= d_mem[r][j_q];
      end
    end
  end

  // Sequencer: load, per-row codon fetch, then nine unit steps per cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      ge_q       <= 8'd2;
      go_q       <= 8'd3;
      fs_q       <= 8'd4;
      dna_cnt_q  <= '0;
      prot_cnt_q <= '0;
      i_q        <= '0;
      j_q        <= '0;
      ds_q       <= '0;
      step_q     <= '0;
      strand_q   <= 1'b0;
      best_q     <= fdpa_pkg::NegScore;
      done_q     <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          fdpa_pkg::REG_GAP_EXTEND: ge_q <= cfg_data_i;
          fdpa_pkg::REG_GAP_OPEN:   go_q <= cfg_data_i;
          fdpa_pkg::REG_FRAMESHIFT: fs_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            case (command_i)
              fdpa_pkg::CMD_DNA: begin
                if (dna_we) dna_cnt_q <= dna_cnt_q + fdpa_pkg::DnaCw'(1);
              end
              fdpa_pkg::CMD_PROT: begin
                if (prot_we) prot_cnt_q <= prot_cnt_q + fdpa_pkg::ProtCw'(1);
              end
              fdpa_pkg::CMD_RUN: begin
                best_q <= fdpa_pkg::NegScore;
                if (run_empty) begin
                  done_q     <= 1'b1;
                  score_q    <= fdpa_pkg::NegScore;
                  empty_q    <= 1'b1;
                  dna_cnt_q  <= '0;
                  prot_cnt_q <= '0;
                end else begin
                  i_q      <= fdpa_pkg::DnaCw'(1);
                  ds_q     <= 2'd1;
                  strand_q <= 1'b0;
                  state_q  <= ST_F0;
                end
              end
              default: ;
            endcase
          end
        end
        ST_F0: begin
          // Row start: column zero of every table reads as zero or -999.
          j_q     <= fdpa_pkg::ColAw'(1);
          iv_q    <= fdpa_pkg::NegScore;
          cprev_q <= '0;
          c2m1_q  <= '0;
          c3m1_q  <= '0;
          old_q   <= '0;
          state_q <= ST_F1;
        end
        ST_F1: begin
          b0_q    <= base_fix;
          state_q <= ST_F2;
        end
        ST_F2: begin
          b1_q    <= base_fix;
          state_q <= ST_F3;
        end
        ST_F3: begin
          b2_q    <= base_fix;
          state_q <= ST_F4;
        end
        ST_F4: begin
          if (b0_q >= fdpa_pkg::BadBase || b1_q >= fdpa_pkg::BadBase ||
              b2_q >= fdpa_pkg::BadBase) begin
            aa_q <= fdpa_pkg::BadRes;
          end else begin
            aa_q <= 5'(fdpa_pkg::CodonAa[{b0_q[1:0], b1_q[1:0], b2_q[1:0]}]);
          end
          state_q <= ST_RD;
        end
        ST_RD: begin
          step_q  <= fdpa_pkg::StepIvA;
          state_q <= ST_EX;
        end
        ST_EX: begin
          acc_q  <= acc_d;
          step_q <= step_q + 4'd1;
          case (step_q)
            fdpa_pkg::StepIvB: iv_q <= c_val;
            fdpa_pkg::StepDB: begin
              if (row_ge4) begin
                d_q <= c_val;
              end else if (row1) begin
                d_q <= -$signed({7'b0, gog});
              end else begin
                d_q <= fdpa_pkg::NegScore;
              end
            end
            fdpa_pkg::StepCFs4: begin
              best_q  <= best_upd;
              cprev_q <= c_val;
              c2m1_q  <= c_rd[c2];
              c3m1_q  <= c_rd[c3];
              old_q   <= c_rd[cs];
              if (!last_col) begin
                j_q     <= j_q + fdpa_pkg::ColAw'(1);
                state_q <= ST_RD;
              end else if (!last_row) begin
                i_q     <= i_q + fdpa_pkg::DnaCw'(1);
                ds_q    <= (ds_q == 2'd2) ? 2'd0 : ds_q + 2'd1;
                state_q <= ST_F0;
              end else if (!strand_q) begin
                strand_q <= 1'b1;
                i_q      <= fdpa_pkg::DnaCw'(1);
                ds_q     <= 2'd1;
                state_q  <= ST_F0;
              end else begin
                done_q     <= 1'b1;
                score_q    <= best_upd;
                empty_q    <= 1'b0;
                dna_cnt_q  <= '0;
                prot_cnt_q <= '0;
                state_q    <= ST_IDLE;
              end
            end
            default: ;
          endcase
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy         = (state_q != ST_IDLE);
  assign cfg_ready_o  = 1'b1;
  assign done_o       = done_q;
  assign best_score_o = score_q;
  assign empty_run_o  = empty_q;

endmodule

@@ tb/sv/fdpa_checker.sv @@
// Checker that predicts the best alignment score of every run and compares it with the block.
`timescale 1ns / 1ps

module fdpa_checker
  import fdpa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         command_i,
  input  logic [7:0]         symbol_i,
  input  logic               done_o,
  input  logic signed [15:0] best_score_o,
  input  logic               empty_run_o,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  output int                 pending_o,
  output int                 errors_o
);

  typedef struct packed {
    logic signed [15:0] score;
    logic               empty;
  } score_beat_t;

  localparam string ResAlphabet = "ARNDCQEGHILKMFPSTWYVBZX*";

  score_beat_t score_q[$];
  logic [7:0]  ge_r, go_r, fs_r;
  logic [2:0]  dna_mem[MaxDna];
  logic [4:0]  prot_mem[MaxProtein];
  int          dna_len, prot_len, best_c;
  int          c_rows[4][Cols];
  int          d_rows[3][Cols];

  assign pending_o = score_q.size();

  function automatic int clip16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int max_of(int a, int b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [4:0] residue_of(logic [7:0] sym);
    for (int k = 0; k < 24; k++) begin
      if (ResAlphabet[k] == sym) return 5'(k);
    end
    return BadRes;
  endfunction

  function automatic int strand_base(bit rev, int k);
    int b;
    b = dna_mem[rev ? (dna_len - 1 - k) : k];
    if (b >= 4) return 4;
    return rev ? 3 - b : b;
  endfunction

  // Score of residue j (from 1) against the codon centered on row i (from 1).
  function automatic int codon_score(bit rev, int i, int j);
    int b0, b1, b2, r, aa;
    b0 = strand_base(rev, i - 1);
    b1 = strand_base(rev, i);
    b2 = strand_base(rev, i + 1);
    r  = prot_mem[j - 1];
    if (b0 >= 4 || b1 >= 4 || b2 >= 4 || r >= 24) return -999;
    aa = CodonAa[b0 * 16 + b1 * 4 + b2];
    return Blosum62[r][aa];
  endfunction

  function automatic void fill_strand(bit rev);
    int ge, go, fs, cs, ds, c2, c3, iv, cprev, prior, s, d, c, nxt;
    ge = ge_r;
    go = go_r;
    fs = fs_r;
    for (int j = 0; j <= prot_len; j++) begin
      for (int r = 0; r < 4; r++) c_rows[r][j] = 0;
      d_rows[0][j] = -999;
    end
    for (int i = 1; i + 2 <= dna_len; i++) begin
      cs = i % 4;
      ds = i % 3;
      c2 = (i - 2) % 4;
      c3 = (i - 3) % 4;
      iv = -999;
      cprev = 0;
      prior = c_rows[cs][0];
      c_rows[cs][0] = 0;
      d_rows[ds][0] = (i == 1) ? -go - ge : -999;
      for (int j = 1; j <= prot_len; j++) begin
        s  = codon_score(rev, i, j);
        iv = clip16(max_of(iv - ge, cprev - go - ge));
        if (i == 1) begin
          d = -go - ge;
          c = max_of(max_of(max_of(iv, d), s), 0);
        end else if (i == 2) begin
          d = -999;
          c = max_of(clip16(max_of(iv, s - fs)), 0);
        end else if (i == 3) begin
          d = -999;
          c = max_of(clip16(max_of(iv, c_rows[1][j - 1] + s - fs)), 0);
        end else begin
          d = clip16(max_of(d_rows[ds][j] - ge, c_rows[c3][j] - go - ge));
          c = max_of(iv, d);
          c = max_of(c, c_rows[c2][j - 1] + s - fs);
          c = max_of(c, c_rows[c3][j - 1] + s);
          c = max_of(c, prior + s - fs);
          c = clip16(c);
        end
        nxt = c_rows[cs][j];
        c_rows[cs][j] = c;
        d_rows[ds][j] = d;
        prior = nxt;
        cprev = c;
        if (i >= 4 && c > best_c) best_c = c;
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    score_beat_t exp_beat, got;
    if (!rst_ni) begin
      ge_r     <= 8'd2;
      go_r     <= 8'd3;
      fs_r     <= 8'd4;
      dna_len  = 0;
      prot_len = 0;
      errors_o <= 0;
      score_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (reg_e'(cfg_index_i))
          REG_GAP_EXTEND: ge_r <= cfg_data_i;
          REG_GAP_OPEN:   go_r <= cfg_data_i;
          REG_FRAMESHIFT: fs_r <= cfg_data_i;
          default: ;
        endcase
      end
      if (done_o) begin
        got.score = best_score_o;
        got.empty = empty_run_o;
        if (score_q.size() == 0) begin
          if (errors_o < 10) $display("[%0t] unexpected result %0d/%0b", $realtime,
                                      got.score, got.empty);
          errors_o <= errors_o + 1;
        end else begin
          exp_beat = score_q.pop_front();
          if (got !== exp_beat) begin
            if (errors_o < 10) $display("[%0t] score mismatch: expected %0d/%0b, got %0d/%0b",
                                        $realtime, exp_beat.score, exp_beat.empty,
                                        got.score, got.empty);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (start && !busy) begin
        case (cmd_e'(command_i))
          CMD_DNA: begin
            if (dna_len < MaxDna) begin
              case (symbol_i)
                "A": dna_mem[dna_len] = 3'd0;
                "C": dna_mem[dna_len] = 3'd1;
                "G": dna_mem[dna_len] = 3'd2;
                "T": dna_mem[dna_len] = 3'd3;
                default: dna_mem[dna_len] = BadBase;
              endcase
              dna_len++;
            end
          end
          CMD_PROT: begin
            if (prot_len < MaxProtein) begin
              prot_mem[prot_len] = residue_of(symbol_i);
              prot_len++;
            end
          end
          CMD_RUN: begin
            best_c = -999;
            exp_beat.empty = (dna_len < 6 || prot_len == 0);
            if (!exp_beat.empty) begin
              fill_strand(1'b0);
              fill_strand(1'b1);
            end
            exp_beat.score = 16'(best_c);
            score_q.push_back(exp_beat);
            dna_len  = 0;
            prot_len = 0;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

@@ tb/sv/tb.sv @@
// Testbench top: drives letters, runs and register writes into the aligner and gives the verdict.
`timescale 1ns / 1ps

module tb;
  import fdpa_pkg::*;

  // The largest runs made here stay far below this many cycles without any beat.
  localparam int WatchLimit = 200000;
  localparam string ResAlphabet = "ARNDCQEGHILKMFPSTWYVBZX*";

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [1:0]         command_i;
  logic [7:0]         symbol_i;
  logic               done_o;
  logic signed [15:0] best_score_o;
  logic               empty_run_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i;
  logic [7:0]         cfg_data_i;
  int                 pending, errors, quiet_cycles;
  bit                 gaps_on;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  frameshift_dna_protein_align DUT (.*);

  fdpa_checker u_checker (
    .clk_i, .rst_ni, .start, .busy, .command_i, .symbol_i, .done_o, .best_score_o,
    .empty_run_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .pending_o(pending), .errors_o(errors)
  );

  // The watchdog restarts on any beat on any channel and on every result.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  // One command beat. start is left high so back-to-back beats need no second
  // assignment in the same step; a gap lowers it explicitly.
  task automatic send(cmd_e cmd, logic [7:0] sym);
    start     <= 1'b1;
    command_i <= cmd;
    symbol_i  <= sym;
    do @(posedge clk_i); while (busy);
    if (gaps_on && $urandom_range(0, 3) == 0) idle_burst();
  endtask

  // Hold the sender until the block is idle and every predicted score has come
  // back. The first edge lets the checker see the last accepted command.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // valid stays high over consecutive writes; the caller lowers it at the end.
  task automatic write_reg(reg_e idx, logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_gaps(logic [7:0] ge, logic [7:0] go, logic [7:0] fs);
    drain();
    write_reg(REG_GAP_EXTEND, ge);
    write_reg(REG_GAP_OPEN, go);
    write_reg(REG_FRAMESHIFT, fs);
    write_reg(REG_UNUSED, 8'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_base();
    if ($urandom_range(0, 19) == 0) return 8'($urandom);
    return 8'("ACGT" >> (8 * $urandom_range(0, 3)));
  endfunction

  function automatic logic [7:0] pick_residue();
    int r;
    r = $urandom_range(0, 24);
    if (r == 24) return ($urandom_range(0, 1) != 0) ? 8'($urandom) : "-";
    return ResAlphabet[r];
  endfunction

  // One well-formed alignment: letters of both strings interleaved at random,
  // an occasional no-op among them, then the run.
  task automatic align_random(int n_dna, int n_prot);
    int nd, np;
    nd = 0;
    np = 0;
    while (nd < n_dna || np < n_prot) begin
      if ($urandom_range(0, 29) == 0) send(CMD_NOP, 8'($urandom));
      if (np >= n_prot || (nd < n_dna && $urandom_range(0, 2) != 0)) begin
        send(CMD_DNA, pick_base());
        nd++;
      end else begin
        send(CMD_PROT, pick_residue());
        np++;
      end
    end
    send(CMD_RUN, 8'($urandom));
  endtask

  task automatic send_text(cmd_e cmd, string txt);
    for (int k = 0; k < txt.len(); k++) send(cmd, txt[k]);
  endtask

  initial begin
    int sent, n, m, sel;
    rst_ni      = 1'b0;
    start       = 1'b0;
    command_i   = CMD_NOP;
    symbol_i    = 8'h00;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_GAP_EXTEND;
    cfg_data_i  = 8'h00;
    gaps_on     = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty run, too few bases, no residues, then a short strand with an
    // invalid base, a lowercase letter, a stop codon, a gap symbol in the protein
    // and the extreme symbol codes.
    send(CMD_RUN, 8'h00);
    send_text(CMD_DNA, "ACGTA");
    send(CMD_PROT, "W");
    send(CMD_RUN, 8'hFF);
    send_text(CMD_DNA, "TAAGCN");
    send(CMD_NOP, 8'hFF);
    send(CMD_RUN, 8'h00);
    send_text(CMD_DNA, "aTAAG");
    send(CMD_DNA, 8'hFF);
    send(CMD_DNA, 8'h00);
    send_text(CMD_PROT, "*-M");
    send(CMD_RUN, 8'h55);

    // Full protein store: appends past capacity are dropped; no bases are
    // loaded so the run returns at once.
    set_gaps(8'd0, 8'd0, 8'd0);
    for (int k = 0; k < MaxProtein + 4; k++) send(CMD_PROT, pick_residue());
    send(CMD_RUN, 8'h00);

    // Random alignments over several gap settings: the reset values, then the extremes, then random ones.
    gaps_on = 1'b1;
    sent = 0;
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: set_gaps(8'd2, 8'd3, 8'd4);
        1: set_gaps(8'd0, 8'd0, 8'd0);
        2: set_gaps(8'd255, 8'd255, 8'd255);
        3: set_gaps(8'd0, 8'd255, 8'd1);
        default: set_gaps(8'($urandom_range(0, 12)), 8'($urandom_range(0, 20)),
                          8'($urandom));
      endcase
      while (sent < (phase + 1) * 50) begin
        // The final stretch runs with no gaps at all.
        if (sent > 280) gaps_on = 1'b0;
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
          n = $urandom_range(6, 16);
          m = $urandom_range(1, 6);
        end else if (sel < 9) begin
          n = $urandom_range(0, 8);
          m = $urandom_range(0, 3);
        end else begin
          n = $urandom_range(17, 40);
          m = $urandom_range(5, 16);
        end
        align_random(n, m);
        sent += n + m + 1;
        // Now and then the sender waits for every outstanding score.
        if ($urandom_range(0, 7) == 0) drain();
      end
    end

    drain();
    repeat (16) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
